// ===== design/cwts_pkg.sv =====
`timescale 1ns / 1ps
package cwts_pkg;

  localparam int HISTORY_DEPTH = 128;
  localparam int PTR_W         = $clog2(HISTORY_DEPTH);
  localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);
  localparam int FRAC_W        = 16;
  localparam int Q_W           = FRAC_W + 1;
  localparam int DVD_W         = CNT_W + FRAC_W;
  localparam int FIDX_W        = 5;
  localparam int TWIN_W        = 16;
  localparam int HWIN_W        = 8;

  localparam logic [Q_W-1:0]    ONE_Q16      = Q_W'(1) << FRAC_W;
  localparam logic [FIDX_W-1:0] LAST_FEATURE = FIDX_W'(18);

  localparam logic [1:0] FLAG_SF  = 2'd0;
  localparam logic [1:0] FLAG_REJ = 2'd1;

  localparam logic [TWIN_W-1:0] TWIN_RESET = TWIN_W'(100);
  localparam logic [HWIN_W-1:0] HWIN_RESET = HWIN_W'(100);

  typedef enum logic {
    REG_TIME_WINDOW = 1'b0,
    REG_HOST_WINDOW = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [31:0] start_sec;
    logic [31:0] dst_addr;
    logic [15:0] dst_port;
    logic [31:0] src_addr;
    logic [15:0] src_port;
    logic [1:0]  flag;
  } rec_t;

  typedef enum logic [3:0] {
    C_T_HOST, C_T_SRV, C_T_HOST_SE, C_T_SRV_SE, C_T_HOST_RE, C_T_SRV_RE,
    C_T_HOST_SRV, C_H_HOST, C_H_HOST_SRV, C_H_SAME_SPORT, C_H_SRV_DIFF,
    C_H_HOST_SE, C_H_SRV_SE, C_H_HOST_RE, C_H_SRV_RE
  } csel_t;

  typedef enum logic [1:0] {K_COUNT, K_RATE, K_DIFF_PREV, K_DIFF_RATE} fkind_t;

  typedef struct packed {
    fkind_t kind;
    csel_t  num;
    csel_t  den;
  } fdesc_t;

  typedef struct packed {
    logic             go;
    logic [CNT_W-1:0] num;
    logic [CNT_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic           done;
    logic [Q_W-1:0] quot;
  } div_rsp_t;

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_FEAT, S_DIV} state_t;

  // Feature table in KDD-99 order
  function automatic fdesc_t feat_desc(input logic [FIDX_W-1:0] f);
    fdesc_t d;
    case (f)
      5'd0:    d = '{K_COUNT,     C_T_HOST,       C_T_HOST};
      5'd1:    d = '{K_COUNT,     C_T_SRV,        C_T_SRV};
      5'd2:    d = '{K_RATE,      C_T_HOST_SE,    C_T_HOST};
      5'd3:    d = '{K_RATE,      C_T_SRV_SE,     C_T_SRV};
      5'd4:    d = '{K_RATE,      C_T_HOST_RE,    C_T_HOST};
      5'd5:    d = '{K_RATE,      C_T_SRV_RE,     C_T_SRV};
      5'd6:    d = '{K_RATE,      C_T_HOST_SRV,   C_T_HOST};
      5'd7:    d = '{K_DIFF_PREV, C_T_HOST,       C_T_HOST};
      5'd8:    d = '{K_DIFF_RATE, C_T_HOST_SRV,   C_T_SRV};
      5'd9:    d = '{K_COUNT,     C_H_HOST,       C_H_HOST};
      5'd10:   d = '{K_COUNT,     C_H_HOST_SRV,   C_H_HOST_SRV};
      5'd11:   d = '{K_RATE,      C_H_HOST_SRV,   C_H_HOST};
      5'd12:   d = '{K_DIFF_PREV, C_H_HOST,       C_H_HOST};
      5'd13:   d = '{K_RATE,      C_H_SAME_SPORT, C_H_HOST};
      5'd14:   d = '{K_RATE,      C_H_SRV_DIFF,   C_H_HOST_SRV};
      5'd15:   d = '{K_RATE,      C_H_HOST_SE,    C_H_HOST};
      5'd16:   d = '{K_RATE,      C_H_SRV_SE,     C_H_HOST_SRV};
      5'd17:   d = '{K_RATE,      C_H_HOST_RE,    C_H_HOST};
      5'd18:   d = '{K_RATE,      C_H_SRV_RE,     C_H_HOST_SRV};
      default: d = '{K_COUNT,     C_T_HOST,       C_T_HOST};
    endcase
    return d;
  endfunction

  function automatic logic [PTR_W-1:0] back_one(input logic [PTR_W-1:0] p);
    return (p == '0) ? PTR_W'(HISTORY_DEPTH - 1) : p - 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] fwd_one(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

endpackage

// ===== design/connection_window_traffic_stats.sv =====
`timescale 1ns / 1ps
// Sequence: a walk over the filled history, then 19 features, each rate with a nonzero
// denominator going through the shared serial divider.
// Throughput: one record at a time; busy stays high until the last feature is out.
// Features leave as 19 one-cycle strobes; the receiver cannot stall them.
// Reset (rst, synchronous): empty history, write pointer 0, time window 100 s,
// host window 100 records. History storage itself is not cleared.
module connection_window_traffic_stats (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] start_sec,
  input  logic [31:0] dst_addr,
  input  logic [15:0] dst_port,
  input  logic [31:0] src_addr,
  input  logic [15:0] src_port,
  input  logic [1:0]  flag_class,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  output logic        feature_valid,
  output logic [4:0]  feature_index,
  output logic [16:0] feature_value,
  output logic        last
);
  import cwts_pkg::*;

  localparam int CMP_W = CNT_W + HWIN_W;

  state_t state, state_next;

  logic [TWIN_W-1:0] time_window;
  logic [HWIN_W-1:0] host_window;
  logic [PTR_W-1:0]  write_ptr;
  logic [CNT_W-1:0]  fill_count;
  rec_t              cur;

  logic [PTR_W-1:0]  rd_ptr, rd_addr;
  logic [CNT_W-1:0]  iss_k, eval_k, host_n;
  logic              eval_valid, time_on, issue;
  rec_t              rd_data;

  logic in_win, sh, ss, se, re, t_hit, h_hit;

  logic [CNT_W-1:0] t_host, t_srv, t_host_se, t_srv_se, t_host_re, t_srv_re, t_host_srv;
  logic [CNT_W-1:0] h_host, h_host_srv, h_same_sport, h_srv_diff;
  logic [CNT_W-1:0] h_host_se, h_srv_se, h_host_re, h_srv_re;

  logic [FIDX_W-1:0] feat;
  fdesc_t            desc;
  logic [CNT_W-1:0]  num_v, den_v;
  logic [Q_W-1:0]    val, prev_rate;
  logic              emit, mem_wr;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      time_window <= TWIN_RESET;
      host_window <= HWIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_TIME_WINDOW: time_window <= cfg_data;
        REG_HOST_WINDOW: host_window <= cfg_data[HWIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Compare one history entry against the current record
  always_comb begin
    rd_addr = back_one(rd_ptr);
    issue   = (state == S_WALK) && (iss_k < fill_count);
    host_n  = (CMP_W'(host_window) < CMP_W'(fill_count)) ? CNT_W'(host_window) : fill_count;
    in_win  = ({1'b0, rd_data.start_sec} + 33'(time_window)) > {1'b0, cur.start_sec};
    sh      = rd_data.dst_addr == cur.dst_addr;
    ss      = rd_data.dst_port == cur.dst_port;
    se      = rd_data.flag != FLAG_SF;
    re      = rd_data.flag == FLAG_REJ;
    t_hit   = eval_valid && time_on && in_win;
    h_hit   = eval_valid && (eval_k < host_n) && sh;
  end

  // Pick numerator and denominator counts for the current feature
  always_comb begin
    desc = feat_desc(feat);
    case (desc.num)
      C_T_HOST:       num_v = t_host;
      C_T_SRV:        num_v = t_srv;
      C_T_HOST_SE:    num_v = t_host_se;
      C_T_SRV_SE:     num_v = t_srv_se;
      C_T_HOST_RE:    num_v = t_host_re;
      C_T_SRV_RE:     num_v = t_srv_re;
      C_T_HOST_SRV:   num_v = t_host_srv;
      C_H_HOST:       num_v = h_host;
      C_H_HOST_SRV:   num_v = h_host_srv;
      C_H_SAME_SPORT: num_v = h_same_sport;
      C_H_SRV_DIFF:   num_v = h_srv_diff;
      C_H_HOST_SE:    num_v = h_host_se;
      C_H_SRV_SE:     num_v = h_srv_se;
      C_H_HOST_RE:    num_v = h_host_re;
      C_H_SRV_RE:     num_v = h_srv_re;
      default:        num_v = '0;
    endcase
    case (desc.den)
      C_T_HOST:       den_v = t_host;
      C_T_SRV:        den_v = t_srv;
      C_T_HOST_SRV:   den_v = t_host_srv;
      C_H_HOST:       den_v = h_host;
      C_H_HOST_SRV:   den_v = h_host_srv;
      default:        den_v = '0;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and sequencer outputs
  always_comb begin
    state_next  = state;
    emit        = 1'b0;
    val         = '0;
    div_req.go  = 1'b0;
    div_req.num = num_v;
    div_req.den = den_v;
    case (state)
      S_IDLE: begin
        if (start) state_next = S_WALK;
      end
      S_WALK: begin
        if (!issue && !eval_valid) state_next = S_FEAT;
      end
      S_FEAT: begin
        case (desc.kind)
          K_COUNT: begin
            emit = 1'b1;
            val  = Q_W'(num_v);
          end
          K_DIFF_PREV: begin
            emit = 1'b1;
            val  = (den_v == '0) ? '0 : ONE_Q16 - prev_rate;
          end
          default: begin
            if (den_v == '0) begin
              emit = 1'b1;
            end else begin
              div_req.go = 1'b1;
              state_next = S_DIV;
            end
          end
        endcase
      end
      S_DIV: begin
        if (div_rsp.done) begin
          emit = 1'b1;
          val  = (desc.kind == K_DIFF_RATE) ? ONE_Q16 - div_rsp.quot : div_rsp.quot;
        end
      end
      default: state_next = S_IDLE;
    endcase
    if (emit) state_next = (feat == LAST_FEATURE) ? S_IDLE : S_FEAT;
    mem_wr = emit && (feat == LAST_FEATURE);
  end

  // Walk control and ring bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      write_ptr     <= '0;
      fill_count    <= '0;
      eval_valid    <= 1'b0;
      time_on       <= 1'b0;
      iss_k         <= '0;
      feat          <= '0;
      feature_valid <= 1'b0;
    end else begin
      eval_valid    <= issue;
      feature_valid <= emit;
      if (state == S_IDLE && start) begin
        iss_k   <= '0;
        time_on <= 1'b1;
        feat    <= '0;
      end
      if (issue) iss_k <= iss_k + 1'b1;
      if (eval_valid && time_on && !in_win) time_on <= 1'b0;
      if (emit) feat <= feat + 1'b1;
      if (mem_wr) begin
        write_ptr <= fwd_one(write_ptr);
        if (fill_count < CNT_W'(HISTORY_DEPTH)) fill_count <= fill_count + 1'b1;
      end
    end
  end

  // Capture record, advance read pointer, accumulate counts, drive result
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      cur <= '{start_sec, dst_addr, dst_port, src_addr, src_port, flag_class};
      rd_ptr <= write_ptr;
      {t_host, t_srv, t_host_se, t_srv_se, t_host_re, t_srv_re, t_host_srv} <= '0;
      {h_host, h_host_srv, h_same_sport, h_srv_diff} <= '0;
      {h_host_se, h_srv_se, h_host_re, h_srv_re} <= '0;
    end
    if (issue) begin
      rd_ptr <= rd_addr;
      eval_k <= iss_k;
    end
    if (t_hit && sh) begin
      t_host <= t_host + 1'b1;
      if (se) t_host_se  <= t_host_se + 1'b1;
      if (re) t_host_re  <= t_host_re + 1'b1;
      if (ss) t_host_srv <= t_host_srv + 1'b1;
    end
    if (t_hit && ss) begin
      t_srv <= t_srv + 1'b1;
      if (se) t_srv_se <= t_srv_se + 1'b1;
      if (re) t_srv_re <= t_srv_re + 1'b1;
    end
    if (h_hit) begin
      h_host <= h_host + 1'b1;
      if (se) h_host_se <= h_host_se + 1'b1;
      if (re) h_host_re <= h_host_re + 1'b1;
      if (rd_data.src_port == cur.src_port) h_same_sport <= h_same_sport + 1'b1;
      if (ss) begin
        h_host_srv <= h_host_srv + 1'b1;
        if (se) h_srv_se <= h_srv_se + 1'b1;
        if (re) h_srv_re <= h_srv_re + 1'b1;
        if (rd_data.src_addr != cur.src_addr) h_srv_diff <= h_srv_diff + 1'b1;
      end
    end
    if (emit) begin
      prev_rate     <= val;
      feature_index <= feat;
      feature_value <= val;
      last          <= (feat == LAST_FEATURE);
    end
  end

  cwts_hist_mem u_mem (
    .clk     (clk),
    .wr_en   (mem_wr),
    .wr_addr (write_ptr),
    .wr_data (cur),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  cwts_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("record transfer did not raise busy");
  a_last_index: assert property (@(posedge clk) disable iff (rst)
    feature_valid |-> (last == (feature_index == LAST_FEATURE)))
    else $error("last marks the wrong feature");
  a_div_in_state: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == S_DIV) else $error("divider result outside wait");
  a_value_bound: assert property (@(posedge clk) disable iff (rst)
    feature_valid |-> feature_value <= ONE_Q16) else $error("feature out of range");

endmodule

// ===== design/cwts_hist_mem.sv =====
`timescale 1ns / 1ps
module cwts_hist_mem (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [cwts_pkg::PTR_W-1:0] wr_addr,
  input  cwts_pkg::rec_t            wr_data,
  input  logic [cwts_pkg::PTR_W-1:0] rd_addr,
  output cwts_pkg::rec_t            rd_data
);
  import cwts_pkg::*;

  rec_t mem [HISTORY_DEPTH];

  // Write one record
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== design/cwts_div.sv =====
`timescale 1ns / 1ps
module cwts_div (
  input  logic               clk,
  input  logic               rst,
  input  cwts_pkg::div_req_t req,
  output cwts_pkg::div_rsp_t rsp
);
  import cwts_pkg::*;

  localparam int STEP_W = $clog2(DVD_W);

  logic              running;
  logic              done;
  logic [STEP_W-1:0] step;
  logic [DVD_W-1:0]  dvd;
  logic [DVD_W-1:0]  quo;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  den;
  logic [CNT_W:0]    rem_sh;
  logic              fit;

  // Restoring divide, one quotient bit per cycle
  always_comb begin
    rem_sh = {rem, dvd[DVD_W-1]};
    fit    = rem_sh >= {1'b0, den};
  end

  // Sequence control
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        running <= 1'b1;
        step    <= '0;
      end else if (running) begin
        step <= step + 1'b1;
        if (step == STEP_W'(DVD_W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // Load dividend with half-divisor rounding term, then shift
  always_ff @(posedge clk) begin
    if (req.go) begin
      dvd <= {req.num, {FRAC_W{1'b0}}} + DVD_W'(req.den >> 1);
      den <= req.den;
      rem <= '0;
      quo <= '0;
    end else if (running) begin
      dvd <= dvd << 1;
      rem <= fit ? CNT_W'(rem_sh - {1'b0, den}) : rem_sh[CNT_W-1:0];
      quo <= {quo[DVD_W-2:0], fit};
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quo[Q_W-1:0];

  a_done_after_run: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(running)) else $error("divider done without a run");
  a_quot_bound: assert property (@(posedge clk) disable iff (rst)
    done && den != '0 && $past(running, DVD_W) |-> rsp.quot <= ONE_Q16)
    else $error("rate above one");
  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    running |-> !req.go) else $error("divider restarted while running");

endmodule
